// ===== design/dsfw_pkg.sv =====
package dsfw_pkg;

  localparam int TEX_DIM_DEF = 512;

  localparam logic [1:0] OP_DRAW   = 2'd0;
  localparam logic [1:0] OP_REDRAW = 2'd1;
  localparam logic [1:0] OP_ERASE  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] REG_SCALE_X = 2'd0;
  localparam logic [1:0] REG_SCALE_Y = 2'd1;
  localparam logic [1:0] REG_WIDE    = 2'd2;
  localparam logic [1:0] REG_TALL    = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture the item
    logic row_init;   // set up the row counter for a new disc
    logic sqrt_start; // begin the square root of the current row
    logic sqrt_step;  // one root digit
    logic mul_a;      // products of the span ends and rows
    logic mul_b;      // round and clip
    logic side_b;     // select the lower row
    logic col_load;   // load column counter from the span start
    logic col_read;   // issue a store read at the current column
    logic col_write;  // write back the read texel
    logic row_next;   // advance to the next row
    logic clr_step;   // clearing pass: write zero and advance
    logic rd_issue;   // issue the read of a read item
    logic done;       // present the result word
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_read;
    logic rows_left;  // yl < radius
    logic sqrt_last;
    logic row_ok;     // current row inside the texture
    logic span_left;  // column < span end
    logic clr_last;
  } sts_t;

endpackage

// ===== design/dsfw_ctrl.sv =====
module dsfw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  dsfw_pkg::sts_t sts,
  output dsfw_pkg::ctl_t ctl
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ROW, S_SQRT, S_MULA, S_MULB, S_SIDE, S_COLRD,
    S_COLWR, S_RDWAIT, S_RDOUT
  } state_t;

  state_t state;
  logic   side;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      side  <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: if (sts.clr_last) state <= S_IDLE;
        S_IDLE: if (start) begin
          state <= sts.is_read ? S_RDWAIT : S_ROW;
        end
        S_ROW: state <= sts.rows_left ? S_SQRT : S_IDLE;
        S_SQRT: if (sts.sqrt_last) state <= S_MULA;
        S_MULA: state <= S_MULB;
        S_MULB: begin
          side  <= 1'b0;
          state <= S_SIDE;
        end
        // skip an empty or off-texture side; after the lower side advance the row
        S_SIDE: begin
          if (sts.row_ok && sts.span_left) begin
            state <= S_COLRD;
          end else begin
            state <= side ? S_ROW : S_SIDE;
            side  <= 1'b1;
          end
        end
        S_COLRD: state <= S_COLWR;
        S_COLWR: begin
          if (sts.span_left) begin
            state <= S_COLRD;
          end else begin
            state <= side ? S_ROW : S_SIDE;
            side  <= 1'b1;
          end
        end
        S_RDWAIT: state <= S_RDOUT;
        S_RDOUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ctl            = '0;
    busy           = (state != S_IDLE);
    ctl.load       = (state == S_IDLE) && start;
    ctl.row_init   = ctl.load;
    ctl.sqrt_start = (state == S_ROW) && sts.rows_left;
    ctl.sqrt_step  = (state == S_SQRT);
    ctl.mul_a      = (state == S_MULA);
    ctl.mul_b      = (state == S_MULB);
    ctl.side_b     = side;
    ctl.col_load   = (state == S_SIDE);
    ctl.col_read   = (state == S_COLRD);
    ctl.col_write  = (state == S_COLWR);
    ctl.row_next   = ((state == S_SIDE) && side && !(sts.row_ok && sts.span_left)) ||
                     ((state == S_COLWR) && side && !sts.span_left);
    ctl.clr_step   = (state == S_CLEAR);
    ctl.rd_issue   = (state == S_RDWAIT);
    ctl.done       = (state == S_RDOUT) ||
                     ((state == S_ROW) && !sts.rows_left);
  end

endmodule

// ===== design/dsfw_dpath.sv =====
module dsfw_dpath #(
  parameter int TEX_DIM = dsfw_pkg::TEX_DIM_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  dsfw_pkg::ctl_t      ctl,
  output dsfw_pkg::sts_t      sts,
  input  logic [1:0]          operation,
  input  logic [15:0]         center_x,
  input  logic [15:0]         center_y,
  input  logic [11:0]         radius,
  input  logic [31:0]         paint_color,
  input  logic [8:0]          read_col,
  input  logic [8:0]          read_row,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [23:0]         cfg_data,
  output logic                done,
  output logic [31:0]         pixel_value,
  output logic                was_read
);

  localparam int AW = $clog2(TEX_DIM);
  localparam int MW = 2 * AW;
  localparam int DEPTH = TEX_DIM * TEX_DIM;

  // configuration
  logic [23:0] scale_x, scale_y;
  logic        wide_texture, tall_texture;
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x <= 24'd65536;
      scale_y <= 24'd65536;
      wide_texture <= 1'b0;
      tall_texture <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        dsfw_pkg::REG_SCALE_X: scale_x <= cfg_data;
        dsfw_pkg::REG_SCALE_Y: scale_y <= cfg_data;
        dsfw_pkg::REG_WIDE:    wide_texture <= cfg_data[0];
        dsfw_pkg::REG_TALL:    tall_texture <= cfg_data[0];
      endcase
    end
  end

  logic [AW:0] width, height;
  assign width  = wide_texture ? (AW+1)'(TEX_DIM) : (AW+1)'(TEX_DIM / 2);
  assign height = tall_texture ? (AW+1)'(TEX_DIM) : (AW+1)'(TEX_DIM / 2);

  // item registers
  logic [1:0]  op;
  logic [15:0] cx, cy;
  logic [11:0] r;
  logic [31:0] color;
  logic [8:0]  rcol, rrow;
  logic [11:0] yl;
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op <= operation; cx <= center_x; cy <= center_y; r <= radius;
      color <= paint_color; rcol <= read_col; rrow <= read_row;
    end
    if (ctl.row_init) yl <= '0;
    else if (ctl.row_next) yl <= yl + 12'd1;
  end

  // bit-pair square root of (r^2 - yl^2) << 8, 32-bit radicand, 16-bit root
  logic [33:0] rem;
  logic [17:0] root;
  logic [31:0] rad;
  logic [4:0]  sq_cnt;
  logic [23:0] rsq, ysq;
  assign rsq = 24'(r) * 24'(r);
  assign ysq = 24'(yl) * 24'(yl);
  logic [33:0] trial;
  assign trial = {rem[31:0], rad[31:30]} - {14'd0, root, 2'b01};
  always_ff @(posedge clk) begin
    if (ctl.sqrt_start) begin
      rad    <= {rsq - ysq, 8'd0};
      rem    <= '0;
      root   <= '0;
      sq_cnt <= '0;
    end else if (ctl.sqrt_step) begin
      rad    <= {rad[29:0], 2'b00};
      sq_cnt <= sq_cnt + 5'd1;
      if (!trial[33]) begin
        rem  <= trial;
        root <= {root[16:0], 1'b1};
      end else begin
        rem  <= {rem[31:0], rad[31:30]};
        root <= {root[16:0], 1'b0};
      end
    end
  end
  assign sts.sqrt_last = (sq_cnt == 5'd15);

  // span ends and rows: products registered before rounding
  logic signed [21:0] xa, xb;
  logic signed [17:0] ya_w, yb_w;
  logic signed [46:0] px1, px2;
  logic signed [42:0] pya, pyb;
  assign xa   = $signed({2'b0, cx, 4'b0}) - $signed({6'b0, root[15:0]});
  assign xb   = $signed({2'b0, cx, 4'b0}) + $signed({6'b0, root[15:0]});
  assign ya_w = $signed({2'b0, cy}) + $signed({6'b0, yl});
  assign yb_w = $signed({2'b0, cy}) - $signed({6'b0, yl});
  always_ff @(posedge clk) begin
    if (ctl.mul_a) begin
      px1 <= 47'(xa * $signed({1'b0, scale_x}));
      px2 <= 47'(xb * $signed({1'b0, scale_x}));
      pya <= 43'(ya_w * $signed({1'b0, scale_y}));
      pyb <= 43'(yb_w * $signed({1'b0, scale_y}));
    end
  end

  // floor((v + half) >> s): arithmetic shift gives floor
  logic signed [46:0] x1s, x2s;
  logic signed [42:0] yas, ybs;
  assign x1s = (px1 + 47'sd524288) >>> 20;
  assign x2s = (px2 + 47'sd524288) >>> 20;
  assign yas = (pya + 43'sd32768) >>> 16;
  assign ybs = (pyb + 43'sd32768) >>> 16;

  logic [AW:0] x_lo, x_hi, row_a, row_b;
  logic        a_ok, b_ok;
  always_ff @(posedge clk) begin
    if (ctl.mul_b) begin
      x_lo  <= x1s[46] ? '0 : (x1s > 47'(width) ? width : (AW+1)'(x1s));
      x_hi  <= x2s[46] ? '0 : (x2s > 47'(width) ? width : (AW+1)'(x2s));
      a_ok  <= !yas[42] && (yas < 43'(height));
      b_ok  <= !ybs[42] && (ybs < 43'(height));
      row_a <= (AW+1)'(yas);
      row_b <= (AW+1)'(ybs);
    end
  end

  logic [AW:0] col;
  always_ff @(posedge clk) begin
    if (ctl.col_load) col <= x_lo;
    else if (ctl.col_write) col <= col + 1'b1;
  end
  logic [AW:0] col_nx;
  assign col_nx = ctl.col_write ? col + 1'b1 : x_lo;

  assign sts.is_read   = (operation == dsfw_pkg::OP_READ);
  assign sts.rows_left = (yl < r);
  assign sts.row_ok    = ctl.side_b ? b_ok : a_ok;
  assign sts.span_left = (col_nx < x_hi);

  // texel store with clearing pass
  logic [31:0]   mem [DEPTH];
  logic [MW-1:0] clr_addr;
  logic [31:0]   rdata;
  logic [MW-1:0] paddr, raddr;
  logic [AW-1:0] prow;
  logic [AW:0]   rcol_x, rrow_x;
  assign prow   = ctl.side_b ? row_b[AW-1:0] : row_a[AW-1:0];
  assign paddr  = {prow, col[AW-1:0]};
  assign rcol_x = (AW+1)'(rcol);
  assign rrow_x = (AW+1)'(rrow);
  assign raddr  = {rrow_x[AW-1:0], rcol_x[AW-1:0]};
  assign sts.clr_last = (clr_addr == MW'(DEPTH - 1));

  logic [31:0] wdata;
  always_comb begin
    unique case (op)
      dsfw_pkg::OP_DRAW:   wdata = color;
      dsfw_pkg::OP_REDRAW: wdata = (rdata == 32'd0) ? color : rdata;
      dsfw_pkg::OP_ERASE:  wdata = (rdata == color) ? 32'd0 : rdata;
      default:             wdata = rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (ctl.clr_step) clr_addr <= clr_addr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ctl.clr_step) mem[clr_addr] <= 32'd0;
    else if (ctl.col_write) mem[paddr] <= wdata;
    if (ctl.col_read) rdata <= mem[paddr];
    else if (ctl.rd_issue) rdata <= mem[raddr];
  end

  logic rd_in;
  always_ff @(posedge clk) begin
    if (ctl.rd_issue)
      rd_in <= (32'(rcol) < 32'(width)) && (32'(rrow) < 32'(height));
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= ctl.done;
    if (ctl.done) begin
      was_read    <= (op == dsfw_pkg::OP_READ);
      pixel_value <= (op == dsfw_pkg::OP_READ && rd_in) ? rdata : 32'd0;
    end
  end

endmodule

// ===== design/disc_span_fill_with_write_modes.sv =====
// Read: S_RDWAIT issues the store read, then S_RDOUT presents the word.
//   Paint, per row: a check, 16 root steps, two product states, a state per row
//   side, then a read and a write per texel; at the end one check and the strobe.
// Throughput: one item at a time; busy falls in the cycle of the result strobe.
// Reset: synchronous; a clearing pass then writes zero to all TEX_DIM*TEX_DIM
//   texels, one a cycle, holding busy high; configuration writes still land.
// The receiver cannot stall: done marks each result word for one cycle.
module disc_span_fill_with_write_modes #(
  parameter int TEX_DIM = dsfw_pkg::TEX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [15:0] center_x,
  input  logic [15:0] center_y,
  input  logic [11:0] radius,
  input  logic [31:0] paint_color,
  input  logic [8:0]  read_col,
  input  logic [8:0]  read_row,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [23:0] cfg_data,
  output logic        done,
  output logic [31:0] pixel_value,
  output logic        was_read
);

  dsfw_pkg::ctl_t ctl;
  dsfw_pkg::sts_t sts;

  // sequence rows, root steps and texel read-modify-write
  dsfw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
  );

  // hold configuration, compute spans, own the texel store
  dsfw_dpath #(.TEX_DIM(TEX_DIM)) u_dpath (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .operation(operation), .center_x(center_x), .center_y(center_y),
    .radius(radius), .paint_color(paint_color), .read_col(read_col),
    .read_row(read_row), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .done(done), .pixel_value(pixel_value),
    .was_read(was_read)
  );

endmodule

// ===== bench/tb_disc_span_fill_with_write_modes.sv =====
`timescale 1ns / 100ps

module tb_disc_span_fill_with_write_modes;

  localparam int DIM = dsfw_pkg::TEX_DIM_DEF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation = dsfw_pkg::OP_READ;
  logic [15:0] center_x = '0;
  logic [15:0] center_y = '0;
  logic [11:0] radius = '0;
  logic [31:0] paint_color = '0;
  logic [8:0]  read_col = '0;
  logic [8:0]  read_row = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = dsfw_pkg::REG_SCALE_X;
  logic [23:0] cfg_data = '0;
  logic        done;
  logic [31:0] pixel_value;
  logic        was_read;

  // one command word as it goes to the block
  typedef struct {
    logic [1:0]  op;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [11:0] rad;
    logic [31:0] color;
    logic [8:0]  col;
    logic [8:0]  row;
  } job_t;

  typedef struct {
    logic [31:0] pix;
    logic        rd;
  } answer_t;

  job_t        pending_jobs[$];
  answer_t     expected_answers[$];
  int          mismatches = 0;
  bit          calm = 1'b0;

  // shadow of the texel store and the registers
  logic [31:0] texels[0:DIM*DIM-1];
  logic [23:0] scl_x = 24'h010000;
  logic [23:0] scl_y = 24'h010000;
  logic        wide_q = 1'b0;
  logic        tall_q = 1'b0;
  logic [31:0] palette[0:3];

  disc_span_fill_with_write_modes uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .center_x(center_x), .center_y(center_y),
    .radius(radius), .paint_color(paint_color), .read_col(read_col),
    .read_row(read_row), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .done(done), .pixel_value(pixel_value),
    .was_read(was_read)
  );

  always #2 clk = ~clk;

  // bit-serial integer root, floor
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // paint columns [x1,x2) of one row, clipped to the texture in use
  function automatic void paint_span(longint rw, longint x1, longint x2,
                                     logic [1:0] op, logic [31:0] color);
    longint w;
    longint h;
    int     a;
    w = wide_q ? DIM : DIM / 2;
    h = tall_q ? DIM : DIM / 2;
    if (rw < 0 || rw >= h) return;
    if (x1 < 0) x1 = 0;
    if (x2 > w) x2 = w;
    for (longint x = x1; x < x2; x++) begin
      a = int'(rw * DIM + x);
      case (op)
        dsfw_pkg::OP_DRAW: texels[a] = color;
        dsfw_pkg::OP_REDRAW: begin
          if (texels[a] == 32'd0) texels[a] = color;
        end
        default: begin
          if (texels[a] == color) texels[a] = 32'd0;
        end
      endcase
    end
  endfunction

  // apply one command to the shadow store and return the answer it causes
  function automatic answer_t predict_answer(job_t j);
    answer_t ans;
    longint  cx;
    longint  cy;
    longint  r;
    longint  xl;
    longint  x1;
    longint  x2;
    longint  ya;
    longint  yb;
    ans.pix = 32'd0;
    ans.rd = 1'b0;
    if (j.op == dsfw_pkg::OP_READ) begin
      ans.rd = 1'b1;
      if (j.col < (wide_q ? DIM : DIM / 2) && j.row < (tall_q ? DIM : DIM / 2))
        ans.pix = texels[int'(j.row) * DIM + int'(j.col)];
      return ans;
    end
    cx = j.cx;
    cy = j.cy;
    r = j.rad;
    for (longint yl = 0; yl < r; yl++) begin
      xl = longint'(root_floor(longint'(r * r - yl * yl) << 8));
      // arithmetic shift of value + half gives round half up
      x1 = (((cx << 4) - xl) * longint'(scl_x) + (64'sd1 <<< 19)) >>> 20;
      x2 = (((cx << 4) + xl) * longint'(scl_x) + (64'sd1 <<< 19)) >>> 20;
      ya = ((cy + yl) * longint'(scl_y) + (64'sd1 <<< 15)) >>> 16;
      yb = ((cy - yl) * longint'(scl_y) + (64'sd1 <<< 15)) >>> 16;
      paint_span(ya, x1, x2, j.op, j.color);
      paint_span(yb, x1, x2, j.op, j.color);
    end
    return ans;
  endfunction

  // driver: hold start until the block takes the word, then maybe idle
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_answers.insert(expected_answers.size(),
                                predict_answer(pending_jobs.pop_front()));
      end
      if ((!start || !busy) && pending_jobs.size() != 0 &&
          (calm || $urandom_range(0, 99) >= 28)) begin
        start <= 1'b1;
        operation <= pending_jobs[0].op;
        center_x <= pending_jobs[0].cx;
        center_y <= pending_jobs[0].cy;
        radius <= pending_jobs[0].rad;
        paint_color <= pending_jobs[0].color;
        read_col <= pending_jobs[0].col;
        read_row <= pending_jobs[0].row;
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobed word must match the oldest expectation
  always @(posedge clk) begin
    answer_t e;
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: pixel_value=%h was_read=%b", pixel_value, was_read);
      end else begin
        e = expected_answers.pop_front();
        if (pixel_value !== e.pix || was_read !== e.rd) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected pixel_value=%h was_read=%b, got %h %b",
                     e.pix, e.rd, pixel_value, was_read);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dsfw_pkg::REG_SCALE_X: scl_x = val;
      dsfw_pkg::REG_SCALE_Y: scl_y = val;
      dsfw_pkg::REG_WIDE:    wide_q = val[0];
      default:               tall_q = val[0];
    endcase
  endtask

  task automatic push_job(logic [1:0] op, logic [15:0] cx, logic [15:0] cy,
                          logic [11:0] rad, logic [31:0] color,
                          logic [8:0] col, logic [8:0] row);
    job_t j;
    j.op = op; j.cx = cx; j.cy = cy; j.rad = rad;
    j.color = color; j.col = col; j.row = row;
    pending_jobs.insert(pending_jobs.size(), j);
  endtask

  // drain: wait until every word is sent and answered
  task automatic drain();
    while (pending_jobs.size() != 0 || start || expected_answers.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // random word; radius kept small so paints stay short
  task automatic push_random(int max_rad);
    logic [1:0]  op;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [31:0] color;
    op = 2'($urandom_range(0, 3));
    color = ($urandom_range(0, 9) == 0) ? $urandom() : palette[$urandom_range(0, 3)];
    if ($urandom_range(0, 9) == 0) begin
      cx = 16'($urandom());
      cy = 16'($urandom());
    end else begin
      cx = 16'($urandom_range(0, 300));
      cy = 16'($urandom_range(0, 300));
    end
    push_job(op, cx, cy, 12'($urandom_range(0, max_rad)), color,
             9'($urandom()), 9'($urandom()));
  endtask

  initial begin
    for (int i = 0; i < DIM * DIM; i++) texels[i] = 32'd0;
    palette[0] = $urandom();
    palette[1] = $urandom();
    palette[2] = 32'hFFFF_FFFF;
    palette[3] = $urandom();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: defaults, 256 x 256 texture at unit scale
    push_job(dsfw_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
    push_job(dsfw_pkg::OP_DRAW, 40, 40, 0, 32'hFFFF_FFFF, 0, 0);
    push_job(dsfw_pkg::OP_DRAW, 0, 0, 1, 32'hFFFF_FFFF, 0, 0);
    push_job(dsfw_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
    push_job(dsfw_pkg::OP_DRAW, 20, 20, 6, palette[0], 0, 0);
    push_job(dsfw_pkg::OP_REDRAW, 24, 20, 6, palette[1], 0, 0);
    push_job(dsfw_pkg::OP_READ, 0, 0, 0, 0, 9'd20, 9'd20);
    push_job(dsfw_pkg::OP_READ, 0, 0, 0, 0, 9'd28, 9'd20);
    push_job(dsfw_pkg::OP_ERASE, 20, 20, 6, palette[0], 0, 0);
    push_job(dsfw_pkg::OP_ERASE, 24, 20, 3, 32'h0, 0, 0);
    push_job(dsfw_pkg::OP_READ, 0, 0, 0, 0, 9'd16, 9'd20);
    push_job(dsfw_pkg::OP_DRAW, 255, 255, 5, palette[3], 0, 0);
    push_job(dsfw_pkg::OP_READ, 0, 0, 0, 0, 9'd255, 9'd255);
    push_job(dsfw_pkg::OP_READ, 0, 0, 0, 0, 9'd300, 9'd10);
    push_job(dsfw_pkg::OP_READ, 0, 0, 0, 0, 9'd10, 9'd300);
    push_job(dsfw_pkg::OP_DRAW, 16'hFFFF, 16'hFFFF, 12, 32'h0, 0, 0);
    push_job(dsfw_pkg::OP_READ, 0, 0, 0, 0, 9'd511, 9'd511);
    drain();

    // full texture, zero scale: everything collapses, even the largest disc
    write_reg(dsfw_pkg::REG_WIDE, 24'd1);
    write_reg(dsfw_pkg::REG_TALL, 24'd1);
    write_reg(dsfw_pkg::REG_SCALE_X, 24'd0);
    write_reg(dsfw_pkg::REG_SCALE_Y, 24'd0);
    push_job(dsfw_pkg::OP_DRAW, 16'hFFFF, 16'hFFFF, 12'hFFF, 32'hFFFF_FFFF, 0, 0);
    push_job(dsfw_pkg::OP_READ, 0, 0, 0, 0, 9'd0, 9'd0);
    push_job(dsfw_pkg::OP_READ, 0, 0, 0, 0, 9'd300, 9'd300);
    drain();

    // largest scale on both axes, tiny discs
    write_reg(dsfw_pkg::REG_SCALE_X, 24'hFFFFFF);
    write_reg(dsfw_pkg::REG_SCALE_Y, 24'hFFFFFF);
    push_job(dsfw_pkg::OP_DRAW, 0, 0, 1, palette[1], 0, 0);
    push_job(dsfw_pkg::OP_DRAW, 1, 1, 2, palette[2], 0, 0);
    push_job(dsfw_pkg::OP_READ, 0, 0, 0, 0, 9'd100, 9'd0);
    push_job(dsfw_pkg::OP_READ, 0, 0, 0, 0, 9'd511, 9'd255);
    drain();

    // random phases over several settings; one runs with no idling at all
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(dsfw_pkg::REG_SCALE_X, 24'h010000);
          write_reg(dsfw_pkg::REG_SCALE_Y, 24'h010000);
        end
        1: begin
          write_reg(dsfw_pkg::REG_SCALE_X, 24'h008000);
          write_reg(dsfw_pkg::REG_SCALE_Y, 24'h020000);
        end
        default: begin
          write_reg(dsfw_pkg::REG_SCALE_X, 24'($urandom_range(24'h004000, 24'h020000)));
          write_reg(dsfw_pkg::REG_SCALE_Y, 24'($urandom_range(24'h004000, 24'h020000)));
        end
      endcase
      write_reg(dsfw_pkg::REG_WIDE, 24'($urandom_range(0, 1)));
      write_reg(dsfw_pkg::REG_TALL, 24'($urandom_range(0, 1)));
      calm = (ph == 2);
      for (int k = 0; k < 30; k++) push_random(24);
      drain();
    end
    calm = 1'b0;

    if (mismatches == 0 && expected_answers.size() == 0)
      $display("tb_disc_span_fill_with_write_modes passed");
    else
      $display("tb_disc_span_fill_with_write_modes failed");
    $finish;
  end

  // watchdog: far beyond the clearing pass plus the slowest paints
  initial begin
    #40_000_000;
    $display("tb_disc_span_fill_with_write_modes failed");
    $finish;
  end

endmodule
